>>> src/tiffhp_pkg.sv
// ----------------------------------------------------------------------------
// TIFF header parser package
// Shared item types, result kinds, parser phases and queue sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package tiffhp_pkg;

  // Result queue sizing
  localparam int unsigned RQ_DEPTH = 4;
  localparam int unsigned RQ_PTR_W = $clog2(RQ_DEPTH);
  localparam int unsigned RQ_CNT_W = $clog2(RQ_DEPTH + 1);

  // File constants
  localparam logic [7:0]  BYTE_ORDER_LE = 8'd73;
  localparam logic [31:0] TIFF_MAGIC    = 32'd42;
  localparam logic [31:0] HEADER_BYTES  = 32'd8;
  localparam logic [15:0] TAG_WIDTH     = 16'd256;
  localparam logic [15:0] TAG_HEIGHT    = 16'd257;

  // Result kinds
  localparam logic [1:0] KIND_PIXEL        = 2'd0;
  localparam logic [1:0] KIND_DIMS         = 2'd1;
  localparam logic [1:0] KIND_BAD_MAGIC    = 2'd2;
  localparam logic [1:0] KIND_OFFSET_SMALL = 2'd3;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_SKIP   = 4'd1,
    PH_MAGIC  = 4'd2,
    PH_OFFSET = 4'd3,
    PH_PIXELS = 4'd4,
    PH_COUNT  = 4'd5,
    PH_ENTRY  = 4'd6,
    PH_NEXT   = 4'd7,
    PH_DONE   = 4'd8
  } phase_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       start_of_file;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] image_width;
    logic [15:0] image_height;
  } out_item_t;

  // Result handed from the parser to the result queue
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } front_res_t;

endpackage

`default_nettype wire

>>> src/tiffhp_front.sv
// ----------------------------------------------------------------------------
// TIFF header parser front end
// Classifies each accepted byte by file phase and builds result records.
// ----------------------------------------------------------------------------
`default_nettype none

module tiffhp_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  fire,
  input  wire tiffhp_pkg::in_item_t  item,
  output tiffhp_pkg::front_res_t     res
);
  import tiffhp_pkg::*;

  phase_t      phase, phase_next;
  logic        little_endian, little_endian_next;
  logic [3:0]  cnt, cnt_next;
  logic [31:0] acc, acc_next;
  logic [31:0] pix_left, pix_left_next;
  logic [1:0]  slot, slot_next;
  logic [7:0]  red_hold, red_hold_next;
  logic [7:0]  green_hold, green_hold_next;
  logic [15:0] entries_left, entries_left_next;
  logic [15:0] cur_tag, cur_tag_next;
  logic [15:0] width_seen, width_seen_next;
  logic [15:0] height_seen, height_seen_next;

  logic [7:0]  b;
  logic [31:0] acc_base;
  logic [31:0] acc_take;

  assign b = item.byte_value;

  // Entry fields restart the accumulator at the tag and at the value
  assign acc_base = (phase == PH_ENTRY && (cnt == 4'd0 || cnt == 4'd8)) ? 32'd0 : acc;
  assign acc_take = little_endian ? (acc_base | ({24'd0, b} << {cnt[1:0], 3'b000}))
                                  : {acc_base[23:0], b};

  always_comb begin
    phase_next        = phase;
    little_endian_next = little_endian;
    cnt_next          = cnt;
    acc_next          = acc;
    pix_left_next     = pix_left;
    slot_next         = slot;
    red_hold_next     = red_hold;
    green_hold_next   = green_hold;
    entries_left_next = entries_left;
    cur_tag_next      = cur_tag;
    width_seen_next   = width_seen;
    height_seen_next  = height_seen;
    if (fire) begin
      if (item.start_of_file) begin
        phase_next         = PH_SKIP;
        little_endian_next = (b == BYTE_ORDER_LE);
        cnt_next           = 4'd0;
        acc_next           = 32'd0;
        slot_next          = 2'd0;
        width_seen_next    = 16'd0;
        height_seen_next   = 16'd0;
      end else begin
        unique case (phase)
          PH_SKIP: begin
            phase_next = PH_MAGIC;
            cnt_next   = 4'd0;
            acc_next   = 32'd0;
          end
          PH_MAGIC: begin
            acc_next = acc_take;
            cnt_next = cnt + 4'd1;
            if (cnt == 4'd1) begin
              cnt_next   = 4'd0;
              acc_next   = 32'd0;
              phase_next = (acc_take == TIFF_MAGIC) ? PH_OFFSET : PH_DONE;
            end
          end
          PH_OFFSET: begin
            acc_next = acc_take;
            cnt_next = cnt + 4'd1;
            if (cnt == 4'd3) begin
              cnt_next      = 4'd0;
              acc_next      = 32'd0;
              slot_next     = 2'd0;
              pix_left_next = acc_take - HEADER_BYTES;
              if (acc_take < HEADER_BYTES) begin
                phase_next = PH_DONE;
              end else if (acc_take == HEADER_BYTES) begin
                phase_next = PH_COUNT;
              end else begin
                phase_next = PH_PIXELS;
              end
            end
          end
          PH_PIXELS: begin
            unique case (slot)
              2'd0: begin
                red_hold_next = b;
                slot_next     = 2'd1;
              end
              2'd1: begin
                green_hold_next = b;
                slot_next       = 2'd2;
              end
              default: slot_next = 2'd0;
            endcase
            pix_left_next = pix_left - 32'd1;
            if (pix_left == 32'd1) begin
              phase_next = PH_COUNT;
              cnt_next   = 4'd0;
              acc_next   = 32'd0;
            end
          end
          PH_COUNT: begin
            acc_next = acc_take;
            cnt_next = cnt + 4'd1;
            if (cnt == 4'd1) begin
              entries_left_next = acc_take[15:0];
              cnt_next          = 4'd0;
              acc_next          = 32'd0;
              phase_next        = (acc_take[15:0] == 16'd0) ? PH_NEXT : PH_ENTRY;
            end
          end
          PH_ENTRY: begin
            if (cnt < 4'd2 || cnt == 4'd8 || cnt == 4'd9) begin
              acc_next = acc_take;
            end
            if (cnt == 4'd1) begin
              cur_tag_next = acc_take[15:0];
            end
            if (cnt == 4'd9) begin
              if (cur_tag == TAG_WIDTH) begin
                width_seen_next = acc_take[15:0];
              end else if (cur_tag == TAG_HEIGHT) begin
                height_seen_next = acc_take[15:0];
              end
            end
            cnt_next = cnt + 4'd1;
            if (cnt == 4'd11) begin
              cnt_next          = 4'd0;
              acc_next          = 32'd0;
              entries_left_next = entries_left - 16'd1;
              if (entries_left == 16'd1) begin
                phase_next = PH_NEXT;
              end
            end
          end
          PH_NEXT: begin
            cnt_next = cnt + 4'd1;
            if (cnt == 4'd3) begin
              cnt_next   = 4'd0;
              acc_next   = 32'd0;
              phase_next = PH_DONE;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    res = '0;
    if (fire && !item.start_of_file) begin
      unique case (phase)
        PH_MAGIC: begin
          if (cnt == 4'd1 && acc_take != TIFF_MAGIC) begin
            res.valid     = 1'b1;
            res.item.kind = KIND_BAD_MAGIC;
          end
        end
        PH_OFFSET: begin
          if (cnt == 4'd3 && acc_take < HEADER_BYTES) begin
            res.valid     = 1'b1;
            res.item.kind = KIND_OFFSET_SMALL;
          end
        end
        PH_PIXELS: begin
          if (slot == 2'd2) begin
            res.valid      = 1'b1;
            res.item.kind  = KIND_PIXEL;
            res.item.red   = red_hold;
            res.item.green = green_hold;
            res.item.blue  = b;
          end
        end
        PH_NEXT: begin
          if (cnt == 4'd3) begin
            res.valid             = 1'b1;
            res.item.kind         = KIND_DIMS;
            res.item.image_width  = width_seen;
            res.item.image_height = height_seen;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      little_endian <= 1'b0;
      cnt           <= '0;
      acc           <= '0;
      pix_left      <= '0;
      slot          <= '0;
      red_hold      <= '0;
      green_hold    <= '0;
      entries_left  <= '0;
      cur_tag       <= '0;
      width_seen    <= '0;
      height_seen   <= '0;
    end else begin
      phase         <= phase_next;
      little_endian <= little_endian_next;
      cnt           <= cnt_next;
      acc           <= acc_next;
      pix_left      <= pix_left_next;
      slot          <= slot_next;
      red_hold      <= red_hold_next;
      green_hold    <= green_hold_next;
      entries_left  <= entries_left_next;
      cur_tag       <= cur_tag_next;
      width_seen    <= width_seen_next;
      height_seen   <= height_seen_next;
    end
  end

endmodule

`default_nettype wire

>>> src/tiffhp_rqueue.sv
// ----------------------------------------------------------------------------
// TIFF header parser result queue
// Short first-in first-out buffer between the parser and the result port.
// ----------------------------------------------------------------------------
`default_nettype none

module tiffhp_rqueue (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   wr_en,
  input  wire tiffhp_pkg::out_item_t  wr_data,
  input  wire logic                   rd_en,
  output tiffhp_pkg::out_item_t       rd_data,
  output logic                        full,
  output logic                        empty
);
  import tiffhp_pkg::*;

  out_item_t             mem [RQ_DEPTH];
  logic [RQ_PTR_W-1:0]   wr_ptr;
  logic [RQ_PTR_W-1:0]   rd_ptr;
  logic [RQ_CNT_W-1:0]   count;
  logic                  do_wr;
  logic                  do_rd;

  assign full    = (count == RQ_CNT_W'(RQ_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + RQ_PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + RQ_PTR_W'(1);
      end
      priority if (do_wr && !do_rd) begin
        count <= count + RQ_CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - RQ_CNT_W'(1);
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= RQ_CNT_W'(RQ_DEPTH))
    else $error("result queue count above depth");

  a_count_inc: assert property (@(posedge clk) disable iff (rst)
    (do_wr && !do_rd) |=> count == $past(count) + RQ_CNT_W'(1))
    else $error("result queue count did not advance on write");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == RQ_CNT_W'(RQ_DEPTH)) |-> wr_ptr == rd_ptr)
    else $error("result queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

>>> src/tiff_header_pixel_parser.sv
// ----------------------------------------------------------------------------
// TIFF header and pixel parser
// Parses a TIFF byte stream into pixel, dimension and error results.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: present one file byte on item with push high; the byte is
//   taken at a clock edge with push high and full low. Set start_of_file on
//   the first byte of a file; this also aborts any file in progress.
//   Result channel: while empty is low the oldest result is on result; pop
//   high at a clock edge takes it.
//   Result timing: a byte that completes a result enters the queue at the
//   edge that takes it and then shows on result, when the queue was empty.
//   Throughput: one byte per cycle while full is low; the parser classifies
//   each byte combinationally and each byte yields at most one result.
//   Stall: results wait in a four-entry queue; full rises only while four
//   results are waiting, and input bytes stall until one is popped.
//   Reset: rst (synchronous) empties the queue and returns the parser to
//   idle, where bytes are ignored until one carries start_of_file.
// ----------------------------------------------------------------------------
`default_nettype none

module tiff_header_pixel_parser (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  wire tiffhp_pkg::in_item_t   item,
  output logic                        full,
  input  wire logic                   pop,
  output tiffhp_pkg::out_item_t       result,
  output logic                        empty
);
  import tiffhp_pkg::*;

  front_res_t res;
  logic       fire;

  assign fire = push && !full;

  tiffhp_front u_front (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (item),
    .res  (res)
  );

  tiffhp_rqueue u_rqueue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res.valid),
    .wr_data (res.item),
    .rd_en   (pop),
    .rd_data (result),
    .full    (full),
    .empty   (empty)
  );

endmodule

`default_nettype wire
